FILE: hw/rtl/psu_pkg.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter package
// Shared constants, types and the Paeth predictor for the unfilter block.
// ----------------------------------------------------------------------------
`default_nettype none

package psu_pkg;

  // Line store geometry
  localparam int MaxWidth   = 4096;
  localparam int MaxBpp     = 3;
  localparam int StoreDepth = MaxWidth * MaxBpp;
  localparam int ColW       = $clog2(StoreDepth);

  // Register field widths
  localparam int WidthW   = 13;
  localparam int HeightW  = 16;
  localparam int BppW     = 2;
  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BPP    = 2'd2;

  // Row filter types
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  typedef logic [ColW-1:0] col_t;

  // One data byte on its way from the sequencer to reconstruction
  typedef struct packed {
    logic [7:0] data;
    col_t       col;
    logic [1:0] ch;
    logic       last_byte;
    logic       last_row;
    logic       row_nz;
    logic [2:0] kind;
    logic       bad;
  } item_t;

  // Line store read request
  typedef struct packed {
    logic en;
    col_t addr;
  } mem_rd_t;

  // Line store write-back
  typedef struct packed {
    logic       en;
    col_t       addr;
    logic [7:0] data;
  } mem_wr_t;

  // Paeth predictor: pick the neighbor closest to a + b - c
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic [9:0]        pa;
    logic [9:0]        pb;
    logic [9:0]        pc;
    da = signed'({2'b00, b}) - signed'({2'b00, c});
    db = signed'({2'b00, a}) - signed'({2'b00, c});
    dc = signed'({2'b00, a}) + signed'({2'b00, b}) - signed'({1'b0, c, 1'b0});
    pa = da[9] ? unsigned'(-da) : unsigned'(da);
    pb = db[9] ? unsigned'(-db) : unsigned'(db);
    pc = dc[9] ? unsigned'(-dc) : unsigned'(dc);
    if (pa <= pb && pa <= pc) begin
      paeth = a;
    end else if (pb <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/psu_if.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter channels
// Valid/ready channels for the inflated byte stream and the pixel results.
// ----------------------------------------------------------------------------
`default_nettype none

interface psu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface psu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic [1:0] channel_index;
  logic       row_end;
  logic       image_end;
  logic       unknown_filter;

  modport source (output valid, output pixel_byte, output channel_index,
                  output row_end, output image_end, output unknown_filter,
                  input ready);
  modport sink   (input valid, input pixel_byte, input channel_index,
                  input row_end, input image_end, input unknown_filter,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter
// Undoes the None/Sub/Up/Average/Paeth row filters on an inflated byte stream.
// ----------------------------------------------------------------------------
// A data byte's result goes through the read stage and then the output register.
// Throughput: one byte per cycle unless the output stalls; filter bytes give no
// result. The line store read and the add sit in back-to-back stages.
// Reset clears counters, neighbor bytes and registers (width 1, height 1, 1 bpp);
// the line store is not cleared, row 0 ignores what it reads. Any register write
// restarts the stream at a filter byte of row 0.
`default_nettype none

module png_scanline_unfilter (
  input  wire                          clk,
  input  wire                          rst_n,
  psu_in_if.sink                       in_stream,
  psu_out_if.source                    out_result,
  input  wire                          cfg_we,
  input  wire [psu_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire [psu_pkg::CfgDataW-1:0]  cfg_wdata
);

  logic              s1_free;
  logic              restart;
  logic              item_valid;
  psu_pkg::item_t    item;
  psu_pkg::mem_rd_t  mem_rd;
  psu_pkg::mem_wr_t  mem_wr;
  logic [7:0]        rd_data;

  psu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_stream),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .s1_free    (s1_free),
    .restart    (restart),
    .item_valid (item_valid),
    .item       (item),
    .mem_rd     (mem_rd)
  );

  psu_line_mem u_line_mem (
    .clk       (clk),
    .rd        (mem_rd),
    .wr        (mem_wr),
    .rd_data_r (rd_data)
  );

  psu_recon u_recon (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (restart),
    .item_valid (item_valid),
    .item       (item),
    .rd_data    (rd_data),
    .s1_free    (s1_free),
    .mem_wr     (mem_wr),
    .out_result (out_result)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/psu_line_mem.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter line store
// One row of sample bytes; one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_line_mem (
  input  wire               clk,
  input  psu_pkg::mem_rd_t  rd,
  input  psu_pkg::mem_wr_t  wr,
  output logic [7:0]        rd_data_r
);

  logic [7:0] mem [0:psu_pkg::StoreDepth-1];

  // Write-back port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read port, data held until the next request
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/psu_front.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter sequencer
// Holds the registers, parses filter bytes, tracks column and row, and
// issues the line store read for each data byte.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_front (
  input  wire                               clk,
  input  wire                               rst_n,
  psu_in_if.sink                            in_stream,
  input  wire                               cfg_we,
  input  wire [psu_pkg::CfgIdxW-1:0]        cfg_index,
  input  wire [psu_pkg::CfgDataW-1:0]       cfg_wdata,
  input  wire                               s1_free,
  output logic                              restart,
  output logic                              item_valid,
  output psu_pkg::item_t                    item,
  output psu_pkg::mem_rd_t                  mem_rd
);

  logic [psu_pkg::WidthW-1:0]  width_r;
  logic [psu_pkg::HeightW-1:0] height_r;
  logic [psu_pkg::BppW-1:0]    bpp_r;

  logic                        expect_r;
  psu_pkg::col_t               col_r;
  logic [1:0]                  ch_r;
  logic [psu_pkg::HeightW-1:0] row_r;
  logic [2:0]                  kind_r;
  logic                        bad_r;

  logic [psu_pkg::WidthW-1:0]  eff_w;
  logic [1:0]                  eff_bpp;
  logic [14:0]                 row_bytes;
  psu_pkg::col_t               last_col;
  logic [psu_pkg::HeightW-1:0] last_row_idx;
  logic                        in_acc;
  logic                        last_byte;
  logic                        last_row;
  logic                        cfg_hit;

  // Effective geometry with out-of-range values clamped
  always_comb begin
    if (width_r == '0) begin
      eff_w = psu_pkg::WidthW'(1);
    end else if (width_r > psu_pkg::WidthW'(psu_pkg::MaxWidth)) begin
      eff_w = psu_pkg::WidthW'(psu_pkg::MaxWidth);
    end else begin
      eff_w = width_r;
    end
    eff_bpp      = (bpp_r == 2'd0) ? 2'd1 : bpp_r;
    row_bytes    = 15'(eff_w) * 15'(eff_bpp);
    last_col     = psu_pkg::ColW'(row_bytes - 15'd1);
    last_row_idx = (height_r == '0) ? '0 : height_r - 16'd1;
  end

  assign in_stream.ready = s1_free;
  assign in_acc          = in_stream.valid && s1_free;
  assign last_byte       = (col_r == last_col);
  assign last_row        = last_byte && (row_r == last_row_idx);

  // Register writes; any known index restarts the stream
  always_comb begin
    unique case (cfg_index) inside
      psu_pkg::CFG_WIDTH, psu_pkg::CFG_HEIGHT, psu_pkg::CFG_BPP: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end
  assign restart = cfg_we && cfg_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= psu_pkg::WidthW'(1);
      height_r <= psu_pkg::HeightW'(1);
      bpp_r    <= psu_pkg::BppW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        psu_pkg::CFG_WIDTH:  width_r  <= cfg_wdata[psu_pkg::WidthW-1:0];
        psu_pkg::CFG_HEIGHT: height_r <= cfg_wdata[psu_pkg::HeightW-1:0];
        psu_pkg::CFG_BPP:    bpp_r    <= cfg_wdata[psu_pkg::BppW-1:0];
        default: ;
      endcase
    end
  end

  // Row and column tracking
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      expect_r <= 1'b1;
      col_r    <= '0;
      ch_r     <= '0;
      row_r    <= '0;
      kind_r   <= psu_pkg::FILT_NONE;
      bad_r    <= 1'b0;
    end else if (in_acc) begin
      if (expect_r) begin
        // filter-type byte: unknown types fall back to None
        bad_r    <= (in_stream.stream_byte > 8'd4);
        kind_r   <= (in_stream.stream_byte > 8'd4) ? psu_pkg::FILT_NONE
                                                   : in_stream.stream_byte[2:0];
        expect_r <= 1'b0;
        col_r    <= '0;
        ch_r     <= '0;
      end else if (last_byte) begin
        expect_r <= 1'b1;
        col_r    <= '0;
        ch_r     <= '0;
        row_r    <= last_row ? '0 : row_r + 16'd1;
      end else begin
        col_r <= col_r + psu_pkg::ColW'(1);
        ch_r  <= (ch_r == eff_bpp - 2'd1) ? 2'd0 : ch_r + 2'd1;
      end
    end
  end

  // Data byte handed to reconstruction, line store read issued alongside
  assign item_valid = in_acc && !expect_r;
  always_comb begin
    item.data      = in_stream.stream_byte;
    item.col       = col_r;
    item.ch        = ch_r;
    item.last_byte = last_byte;
    item.last_row  = last_row;
    item.row_nz    = (row_r != '0);
    item.kind      = kind_r;
    item.bad       = bad_r;
    mem_rd.en      = item_valid;
    mem_rd.addr    = col_r;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/psu_recon.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter reconstruction
// Applies the row filter with the left, above and upper-left bytes, writes
// the result back to the line store and holds it in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_recon (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                restart,
  input  wire                item_valid,
  input  psu_pkg::item_t     item,
  input  wire [7:0]          rd_data,
  output logic               s1_free,
  output psu_pkg::mem_wr_t   mem_wr,
  psu_out_if.source          out_result
);

  logic            s1_valid_r;
  psu_pkg::item_t  s1_r;
  logic            s1_adv;

  logic [2:0][7:0] left_r;
  logic [2:0][7:0] upleft_r;

  logic [7:0]      a;
  logic [7:0]      b;
  logic [7:0]      c;
  logic [7:0]      pred;
  logic [7:0]      res;
  logic [8:0]      sum_ab;

  logic            out_valid_r;
  logic [7:0]      pix_r;
  logic [1:0]      ch_r;
  logic            row_end_r;
  logic            image_end_r;
  logic            unk_r;

  assign s1_adv  = s1_valid_r && (!out_valid_r || out_result.ready);
  assign s1_free = !s1_valid_r || s1_adv;

  // Stage holding the byte whose line store read is in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && item_valid) begin
      s1_r <= item;
    end
  end

  // Neighbor selection; left/upper-left are zero at the start of each row
  always_comb begin
    case (s1_r.ch)
      2'd0:    begin a = left_r[0]; c = upleft_r[0]; end
      2'd1:    begin a = left_r[1]; c = upleft_r[1]; end
      2'd2:    begin a = left_r[2]; c = upleft_r[2]; end
      default: begin a = 8'd0;      c = 8'd0;        end
    endcase
    // the line store is only valid once a row has been written
    b      = s1_r.row_nz ? rd_data : 8'd0;
    sum_ab = {1'b0, a} + {1'b0, b};
  end

  // Predictor and modulo-256 add
  always_comb begin
    unique case (s1_r.kind)
      psu_pkg::FILT_NONE:  pred = 8'd0;
      psu_pkg::FILT_SUB:   pred = a;
      psu_pkg::FILT_UP:    pred = b;
      psu_pkg::FILT_AVG:   pred = sum_ab[8:1];
      psu_pkg::FILT_PAETH: pred = psu_pkg::paeth(a, b, c);
      default:             pred = 8'd0;
    endcase
    res = s1_r.data + pred;
  end

  // Write-back; the next row reads this column only after its filter byte
  always_comb begin
    mem_wr.en   = s1_adv;
    mem_wr.addr = s1_r.col;
    mem_wr.data = res;
  end

  // Left and upper-left pixel bytes
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      left_r   <= '0;
      upleft_r <= '0;
    end else if (s1_adv) begin
      if (s1_r.last_byte) begin
        left_r   <= '0;
        upleft_r <= '0;
      end else begin
        case (s1_r.ch)
          2'd0:    begin left_r[0] <= res; upleft_r[0] <= b; end
          2'd1:    begin left_r[1] <= res; upleft_r[1] <= b; end
          2'd2:    begin left_r[2] <= res; upleft_r[2] <= b; end
          default: ;
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_result.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      pix_r       <= res;
      ch_r        <= s1_r.ch;
      row_end_r   <= s1_r.last_byte;
      image_end_r <= s1_r.last_row;
      unk_r       <= s1_r.bad;
    end
  end

  assign out_result.valid          = out_valid_r;
  assign out_result.pixel_byte     = pix_r;
  assign out_result.channel_index  = ch_r;
  assign out_result.row_end        = row_end_r;
  assign out_result.image_end      = image_end_r;
  assign out_result.unknown_filter = unk_r;

  // First byte of a row sees no left or upper-left neighbor
  a_row_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_r.col == '0 |-> left_r == '0 && upleft_r == '0)
    else $error("neighbor bytes not cleared at row start");

  // Unknown filter rows decode as None
  a_bad_is_none: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_r.bad |-> s1_r.kind == psu_pkg::FILT_NONE)
    else $error("unknown filter row not mapped to None");

  // Byte within pixel never exceeds the column
  a_ch_le_col: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> psu_pkg::ColW'(s1_r.ch) <= s1_r.col)
    else $error("channel index ahead of column");

  // A stalled output keeps the stage from writing back
  a_stall_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_result.ready |-> !mem_wr.en)
    else $error("write-back while output stalled");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter testbench
// Streams filter and sample bytes through png_scanline_unfilter under a range
// of image geometries, predicts every reconstructed byte in a local model of
// the row filters and line store, and checks each result field by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import psu_pkg::*;

  // Index with no register behind it; a write there must be ignored
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

  localparam int RandomBytes = 600;
  localparam int CycleLimit  = 300000;
  localparam int IdlePct     = 38;

  // One reconstructed byte as it should leave the block
  typedef struct packed {
    logic [7:0] pixel;
    logic [1:0] ch;
    logic       row_end;
    logic       img_end;
    logic       bad;
  } pixel_rec_t;

  logic clk;
  logic rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  psu_in_if  in_if ();
  psu_out_if out_if ();

  png_scanline_unfilter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_if),
    .out_result (out_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Pending stream bytes and pixels still owed by the block
  logic [7:0] stream_q[$];
  pixel_rec_t pixel_q[$];

  int  mismatches = 0;
  int  cycle_count = 0;
  int  queued_bytes = 0;
  bit  steady = 1'b0;

  // Local copy of the registers and the unfilter state
  logic [WidthW-1:0]  reg_width;
  logic [HeightW-1:0] reg_height;
  logic [BppW-1:0]    reg_bpp;
  logic [7:0]  prior_row [StoreDepth];
  logic [7:0]  left_px [3];
  logic [7:0]  upleft_px [3];
  logic [2:0]  filt_kind;
  bit          filt_bad;
  int unsigned col_pos;
  int unsigned row_num;
  bit          want_filter;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned eff_bpp();
    return (reg_bpp == 0) ? 1 : reg_bpp;
  endfunction

  function automatic int unsigned eff_width();
    if (reg_width == 0) return 1;
    if (reg_width > MaxWidth) return MaxWidth;
    return reg_width;
  endfunction

  function automatic int unsigned eff_height();
    return (reg_height == 0) ? 1 : reg_height;
  endfunction

  function automatic int unsigned row_len();
    return eff_width() * eff_bpp();
  endfunction

  function automatic void restart_stream();
    for (int i = 0; i < 3; i++) begin
      left_px[i]   = 8'h00;
      upleft_px[i] = 8'h00;
    end
    filt_kind   = FILT_NONE;
    filt_bad    = 1'b0;
    col_pos     = 0;
    row_num     = 0;
    want_filter = 1'b1;
  endfunction

  function automatic void reset_model();
    reg_width  = 1;
    reg_height = 1;
    reg_bpp    = 1;
    foreach (prior_row[i]) prior_row[i] = 8'h00;
    restart_stream();
  endfunction

  // Register write as the block sees it; any real register restarts the stream
  function automatic void load_reg(input logic [CfgIdxW-1:0] idx,
                                   input logic [CfgDataW-1:0] val);
    case (idx)
      CFG_WIDTH:  reg_width  = val[WidthW-1:0];
      CFG_HEIGHT: reg_height = val[HeightW-1:0];
      CFG_BPP:    reg_bpp    = val[BppW-1:0];
      default:    return;
    endcase
    restart_stream();
  endfunction

  // Undo the row filter on one accepted byte; filter bytes give no pixel
  function automatic void unfilter_byte(input logic [7:0] x);
    int unsigned bpp;
    int unsigned nbytes;
    int unsigned col;
    int unsigned ch;
    int a, b, c, p, pa, pb, pc, pred;
    logic [7:0] res;
    bit last_byte;
    bit last_row;
    pixel_rec_t rec;
    if (want_filter) begin
      filt_bad    = (x > FILT_PAETH);
      filt_kind   = filt_bad ? FILT_NONE : x[2:0];
      want_filter = 1'b0;
      col_pos     = 0;
      return;
    end
    bpp    = eff_bpp();
    nbytes = row_len();
    col    = (col_pos >= nbytes) ? nbytes - 1 : col_pos;
    ch     = col % bpp;
    // neighbors left of the first pixel or above the first row are zero
    a = (col >= bpp) ? left_px[ch] : 0;
    b = (row_num != 0) ? prior_row[col] : 0;
    c = (col >= bpp && row_num != 0) ? upleft_px[ch] : 0;
    case (filt_kind)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = (a + b) / 2;
      FILT_PAETH: begin
        p  = a + b - c;
        pa = (p > a) ? p - a : a - p;
        pb = (p > b) ? p - b : b - p;
        pc = (p > c) ? p - c : c - p;
        if (pa <= pb && pa <= pc) pred = a;
        else if (pb <= pc) pred = b;
        else pred = c;
      end
      default:    pred = 0;
    endcase
    res = 8'(x + pred);
    left_px[ch]    = res;
    upleft_px[ch]  = 8'(b);
    prior_row[col] = res;
    last_byte = (col + 1 >= nbytes);
    last_row  = last_byte && (row_num + 1 >= eff_height());
    rec.pixel   = res;
    rec.ch      = 2'(ch);
    rec.row_end = last_byte;
    rec.img_end = last_row;
    rec.bad     = filt_bad;
    pixel_q.push_back(rec);
    if (last_byte) begin
      for (int i = 0; i < 3; i++) begin
        left_px[i]   = 8'h00;
        upleft_px[i] = 8'h00;
      end
      col_pos     = 0;
      want_filter = 1'b1;
      row_num     = last_row ? 0 : ((row_num + 1) & 16'hFFFF);
    end else begin
      col_pos = col + 1;
    end
  endfunction

  // Sample bytes lean toward values that make Paeth ties and wraps likely
  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_filter();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(FILT_PAETH + 1, 255));
    return 8'($urandom_range(FILT_NONE, FILT_PAETH));
  endfunction

  // Whole rows at the current geometry, then an optional cut-off row
  function automatic void push_rows(input int rows, input int tail);
    int unsigned n;
    n = row_len();
    for (int r = 0; r < rows; r++) begin
      stream_q.push_back(pick_filter());
      for (int i = 0; i < n; i++) stream_q.push_back(pick_sample());
      queued_bytes += n + 1;
    end
    if (tail > 0) begin
      stream_q.push_back(pick_filter());
      for (int i = 0; i < tail; i++) stream_q.push_back(pick_sample());
      queued_bytes += tail + 1;
    end
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
  endtask

  task automatic check_pixel();
    pixel_rec_t want;
    if (pixel_q.size() == 0) begin
      flag_mismatch("pixel with nothing pending", out_if.pixel_byte, -1);
      return;
    end
    want = pixel_q.pop_front();
    if (out_if.pixel_byte !== want.pixel)
      flag_mismatch("pixel_byte", out_if.pixel_byte, want.pixel);
    if (out_if.channel_index !== want.ch)
      flag_mismatch("channel_index", out_if.channel_index, want.ch);
    if (out_if.row_end !== want.row_end)
      flag_mismatch("row_end", out_if.row_end, want.row_end);
    if (out_if.image_end !== want.img_end)
      flag_mismatch("image_end", out_if.image_end, want.img_end);
    if (out_if.unknown_filter !== want.bad)
      flag_mismatch("unknown_filter", out_if.unknown_filter, want.bad);
  endtask

  // Wait until every request is taken and every pixel is back, plus slack
  // for a trailing filter byte still inside the pipe
  task automatic drain();
    @(negedge clk);
    while (stream_q.size() != 0 || in_if.valid || pixel_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    load_reg(idx, val);
    @(negedge clk);
  endtask

  // Unused upper data bits carry noise; the block must mask them
  task automatic write_geometry(input int w, input int h, input int bpp);
    write_reg(CFG_WIDTH, {3'($urandom), 13'(w)});
    write_reg(CFG_HEIGHT, 16'(h));
    write_reg(CFG_BPP, {14'($urandom), 2'(bpp)});
  endtask

  // Request driver: holds a byte until taken, idles at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) unfilter_byte(in_if.stream_byte);
      if (!in_if.valid || in_if.ready) begin
        if (stream_q.size() != 0 && (steady || $urandom_range(0, 99) >= IdlePct)) begin
          in_if.valid       <= 1'b1;
          in_if.stream_byte <= stream_q.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) check_pixel();
      out_if.ready <= steady || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // Run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.stream_byte = 8'h00;
    out_if.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_WIDTH;
    cfg_wdata         = '0;
    reset_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // One-byte images at reset geometry: every filter type, then unknown ones
    for (int k = FILT_NONE; k <= FILT_PAETH; k++) begin
      stream_q.push_back(8'(k));
      stream_q.push_back(k[0] ? 8'hFF : 8'h00);
    end
    stream_q.push_back(8'd5);
    stream_q.push_back(8'h7F);
    stream_q.push_back(8'hFF);
    stream_q.push_back(8'hFF);

    // Two rows of two bytes: Paeth over a real row above, with wrap
    drain();
    write_geometry(2, 2, 1);
    stream_q.push_back({5'b0, FILT_PAETH});
    stream_q.push_back(8'hFF);
    stream_q.push_back(8'h01);
    stream_q.push_back({5'b0, FILT_PAETH});
    stream_q.push_back(8'h80);
    stream_q.push_back(8'h7F);

    // Zero in every register acts as one
    drain();
    write_geometry(0, 0, 0);
    push_rows(4, 0);

    // Widest row at three bytes per pixel, cut off early
    drain();
    write_geometry(MaxWidth, 1, 3);
    push_rows(0, 60);

    // Tallest image; a write to the spare index must not restart the stream
    drain();
    write_geometry(3, 65535, 3);
    push_rows(2, 5);
    drain();
    write_reg(CFG_SPARE, 16'($urandom));
    push_rows(3, 0);

    // Random geometries; a phase without writes carries on mid-row
    queued_bytes = 0;
    for (int ph = 0; queued_bytes < RandomBytes; ph++) begin
      drain();
      if ($urandom_range(0, 1))
        write_reg(CFG_WIDTH, {3'($urandom), 13'($urandom_range(0, 10))});
      if ($urandom_range(0, 1))
        write_reg(CFG_HEIGHT, 16'($urandom_range(0, 4)));
      if ($urandom_range(0, 1))
        write_reg(CFG_BPP, {14'($urandom), 2'($urandom_range(0, 3))});
      if ($urandom_range(0, 7) == 0)
        write_reg(CFG_SPARE, 16'($urandom));
      steady = (ph == 4);
      push_rows($urandom_range(1, 6),
                (row_len() > 1 && $urandom_range(0, 2) == 0) ?
                  $urandom_range(1, row_len() - 1) : 0);
    end

    // Oversized width register, long cut-off row with no idling
    drain();
    steady = 1'b1;
    write_geometry(13'h1FFF, 2, 1);
    push_rows(0, 150);

    drain();
    steady = 1'b0;
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
